[src/stcd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stcd_pkg
// Shared widths, constants, command/status types and the month length table
// for the seconds-to-calendar-date converter.
// ----------------------------------------------------------------------------
package stcd_pkg;

    // Field and datapath widths
    localparam int unsigned SECS_W    = 39;  // input seconds
    localparam int unsigned REM_W     = 19;  // division remainder before correction
    localparam int unsigned DAY_W     = 18;  // day index inside a 400-year block
    localparam int unsigned YEAR_W    = 15;  // internal year, up to 17599
    localparam int unsigned QBLK_W    = 6;   // count of whole 400-year blocks
    localparam int unsigned OYEAR_W   = 14;
    localparam int unsigned OMONTH_W  = 4;
    localparam int unsigned ODAY_W    = 5;
    localparam int unsigned MAXY_W    = 16;  // range of the year limit

    // Reciprocal division: 86400 = 128 * 675, so drop 7 bits then divide by 675
    localparam int unsigned DAY_SHIFT   = 7;
    localparam int unsigned DVD_W       = SECS_W - DAY_SHIFT;  // 32-bit dividend
    localparam int unsigned QUO_W       = 23;                  // day ordinal
    localparam int unsigned RECIP_W     = 23;
    localparam int unsigned RECIP_SHIFT = 32;

    // Divisors
    localparam logic [REM_W-1:0] SECS_PER_DAY     = 19'd86400;
    localparam logic [REM_W-1:0] DAYS_PER_400Y    = 19'd146097;
    localparam logic [REM_W-1:0] SECS_PER_DAY_ODD = SECS_PER_DAY >> DAY_SHIFT;

    // Truncated reciprocals; the estimate is never high and at most one low
    localparam logic [RECIP_W-1:0] RECIP_DAY =
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(SECS_PER_DAY_ODD));
    localparam logic [RECIP_W-1:0] RECIP_BLK =
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(DAYS_PER_400Y));

    // Calendar constants
    localparam logic [8:0] DAYS_COMMON_YEAR = 9'd365;
    localparam logic [8:0] DAYS_LEAP_YEAR   = 9'd366;
    localparam logic [8:0] YEARS_PER_BLOCK  = 9'd400;
    localparam logic [6:0] YEARS_PER_CENT   = 7'd100;
    localparam logic [8:0] YEARS_PER_QUAD_C = 9'd400;

    // Month numbers
    localparam logic [OMONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [OMONTH_W-1:0] MON_FEB = 4'd2;
    localparam logic [OMONTH_W-1:0] MON_APR = 4'd4;
    localparam logic [OMONTH_W-1:0] MON_JUN = 4'd6;
    localparam logic [OMONTH_W-1:0] MON_SEP = 4'd9;
    localparam logic [OMONTH_W-1:0] MON_NOV = 4'd11;
    localparam logic [OMONTH_W-1:0] MON_DEC = 4'd12;

    localparam logic [ODAY_W-1:0] DAY_LAST = 5'd31;

    localparam int unsigned DEF_MAX_YEAR = 9999;

    // Controller to datapath
    typedef struct packed {
        logic load_in;     // capture seconds
        logic div_est;     // quotient estimate by reciprocal multiplication
        logic div_rem;     // remainder of the estimate
        logic div_fix;     // raise the quotient by one when the remainder fits
        logic div_blk;     // divide by 400-year block length, else by day length
        logic load_ord;    // form the zero-based day index
        logic year_init;   // set year and day index from division results
        logic year_step;   // remove one year
        logic month_step;  // remove one month
        logic out_load;    // place the result in the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic year_done;
        logic month_done;
        logic out_free;
    } t_sts;

    // Days in a month
    function automatic logic [ODAY_W-1:0] month_len(input logic [OMONTH_W-1:0] m,
                                                    input logic leap);
        logic [ODAY_W-1:0] len;
        unique case (m)
            MON_FEB: len = leap ? 5'd29 : 5'd28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

[src/stcd_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stcd_datapath
// Shared reciprocal divider, year and month subtraction registers and the
// output register of the converter.
// ----------------------------------------------------------------------------
module stcd_datapath #(
    parameter int unsigned MAX_YEAR = stcd_pkg::DEF_MAX_YEAR
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  stcd_pkg::t_cmd                   i_cmd,
    output stcd_pkg::t_sts                   o_sts,
    input  wire  [stcd_pkg::SECS_W-1:0]      i_time_seconds,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic [stcd_pkg::OYEAR_W-1:0]     o_year,
    output logic [stcd_pkg::OMONTH_W-1:0]    o_month,
    output logic [stcd_pkg::ODAY_W-1:0]      o_day,
    output logic                             o_year_overflow
);
    import stcd_pkg::*;

    localparam logic [MAXY_W-1:0] MaxYear = MAXY_W'(MAX_YEAR);

    logic [DVD_W-1:0]    r_x;
    logic [QUO_W-1:0]    r_o;
    logic [QUO_W-1:0]    r_q;
    logic [REM_W-1:0]    r_rem;
    logic [YEAR_W-1:0]   r_year;
    logic [6:0]          r_mod100;
    logic [8:0]          r_mod400;
    logic [DAY_W-1:0]    r_d;
    logic [OMONTH_W-1:0] r_month;
    logic                r_out_valid;

    logic [DVD_W-1:0]         mul_a;
    logic [RECIP_W-1:0]       mul_b;
    logic [DVD_W+RECIP_W-1:0] est_prod;
    logic [REM_W-1:0]         divisor;
    logic [2*REM_W-1:0]       back_prod;
    logic [REM_W-1:0]         dvd_lo;
    logic                     fits;
    logic [QUO_W-1:0]         ord_adj;
    logic                     leap;
    logic [8:0]               year_len;
    logic [ODAY_W-1:0]        mon_len;
    logic                     overflow;
    logic [ODAY_W-1:0]        day_out;

    // Quotient estimate: dividend times truncated reciprocal, upper bits
    assign mul_a    = i_cmd.div_blk ? DVD_W'(r_o) : r_x;
    assign mul_b    = i_cmd.div_blk ? RECIP_BLK : RECIP_DAY;
    assign est_prod = mul_a * mul_b;

    // Remainder of the estimate; it is small, so the low bits suffice
    assign divisor   = i_cmd.div_blk ? DAYS_PER_400Y : SECS_PER_DAY_ODD;
    assign back_prod = r_q[REM_W-1:0] * divisor;
    assign dvd_lo    = i_cmd.div_blk ? r_o[REM_W-1:0] : r_x[REM_W-1:0];
    assign fits      = (r_rem >= divisor);

    // Zero-based day index, day zero folded onto day one
    assign ord_adj = (r_q == '0) ? '0 : r_q - QUO_W'(1);

    // Leap rule from the year and its running residues
    assign leap     = ((r_year[1:0] == 2'd0) && (r_mod100 != 7'd0)) || (r_mod400 == 9'd0);
    assign year_len = leap ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
    assign mon_len  = month_len(r_month, leap);

    assign overflow = ({1'b0, r_year} > MaxYear);
    assign day_out  = r_d[ODAY_W-1:0] + ODAY_W'(1);

    // Status to controller
    always_comb begin
        o_sts.year_done  = (r_d < DAY_W'(year_len));
        o_sts.month_done = (r_d < DAY_W'(mon_len)) || (r_month >= MON_DEC);
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    // Capture seconds, whole multiples of 128 only
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x <= i_time_seconds[SECS_W-1:DAY_SHIFT];
        end
    end

    // Quotient and remainder: estimate, remainder, one correction
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_est) begin
            r_q <= est_prod[DVD_W+RECIP_W-1:RECIP_SHIFT];
        end else if (i_cmd.div_rem) begin
            r_rem <= dvd_lo - back_prod[REM_W-1:0];
        end else if (i_cmd.div_fix && fits) begin
            r_q   <= r_q + QUO_W'(1);
            r_rem <= r_rem - divisor;
        end
    end

    // Hold the zero-based day index for the block division
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_ord) begin
            r_o <= ord_adj;
        end
    end

    // Year and month subtraction
    always_ff @(posedge i_clk) begin
        if (i_cmd.year_init) begin
            r_year   <= YEAR_W'(r_q[QBLK_W-1:0]) * YEAR_W'(YEARS_PER_BLOCK);
            r_mod100 <= '0;
            r_mod400 <= '0;
            r_d      <= r_rem[DAY_W-1:0];
            r_month  <= MON_JAN;
        end else if (i_cmd.year_step) begin
            r_year   <= r_year + YEAR_W'(1);
            r_mod100 <= (r_mod100 == YEARS_PER_CENT - 7'd1) ? 7'd0 : r_mod100 + 7'd1;
            r_mod400 <= (r_mod400 == YEARS_PER_QUAD_C - 9'd1) ? 9'd0 : r_mod400 + 9'd1;
            r_d      <= r_d - DAY_W'(year_len);
        end else if (i_cmd.month_step) begin
            r_d     <= r_d - DAY_W'(mon_len);
            r_month <= r_month + OMONTH_W'(1);
        end
    end

    // Output word valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output word payload, saturated on overflow
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_year_overflow <= overflow;
            o_year          <= overflow ? MaxYear[OYEAR_W-1:0] : r_year[OYEAR_W-1:0];
            o_month         <= overflow ? MON_DEC : r_month;
            o_day           <= overflow ? DAY_LAST : day_out;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

[src/stcd_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stcd_ctrl
// Sequencer for the converter: two divisions, year loop, month loop and
// hand-off to the output register.
// ----------------------------------------------------------------------------
module stcd_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    input  stcd_pkg::t_sts  i_sts,
    output stcd_pkg::t_cmd  o_cmd
);
    import stcd_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_DAY_EST = 4'd1;
    localparam logic [3:0] ST_DAY_REM = 4'd2;
    localparam logic [3:0] ST_DAY_FIX = 4'd3;
    localparam logic [3:0] ST_ORD     = 4'd4;
    localparam logic [3:0] ST_BLK_EST = 4'd5;
    localparam logic [3:0] ST_BLK_REM = 4'd6;
    localparam logic [3:0] ST_BLK_FIX = 4'd7;
    localparam logic [3:0] ST_YINIT   = 4'd8;
    localparam logic [3:0] ST_YEAR    = 4'd9;
    localparam logic [3:0] ST_MONTH   = 4'd10;
    localparam logic [3:0] ST_FIN     = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_DAY_EST;
                end
            end
            ST_DAY_EST: begin
                o_cmd.div_est = 1'b1;
                n_state       = ST_DAY_REM;
            end
            ST_DAY_REM: begin
                o_cmd.div_rem = 1'b1;
                n_state       = ST_DAY_FIX;
            end
            ST_DAY_FIX: begin
                o_cmd.div_fix = 1'b1;
                n_state       = ST_ORD;
            end
            ST_ORD: begin
                o_cmd.load_ord = 1'b1;
                n_state        = ST_BLK_EST;
            end
            ST_BLK_EST: begin
                o_cmd.div_est = 1'b1;
                o_cmd.div_blk = 1'b1;
                n_state       = ST_BLK_REM;
            end
            ST_BLK_REM: begin
                o_cmd.div_rem = 1'b1;
                o_cmd.div_blk = 1'b1;
                n_state       = ST_BLK_FIX;
            end
            ST_BLK_FIX: begin
                o_cmd.div_fix = 1'b1;
                o_cmd.div_blk = 1'b1;
                n_state       = ST_YINIT;
            end
            ST_YINIT: begin
                o_cmd.year_init = 1'b1;
                n_state         = ST_YEAR;
            end
            ST_YEAR: begin
                if (i_sts.year_done) begin
                    n_state = ST_MONTH;
                end else begin
                    o_cmd.year_step = 1'b1;
                end
            end
            ST_MONTH: begin
                if (i_sts.month_done) begin
                    n_state = ST_FIN;
                end else begin
                    o_cmd.month_step = 1'b1;
                end
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

[src/seconds_to_calendar_date.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// seconds_to_calendar_date
// Converts seconds since the start of year 0 to a proleptic Gregorian date.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) takes one word of seconds; output
// channel (o_out_valid / i_out_ready) gives year, month, day and an overflow
// flag. One result word per input word, in order.
// Steps: accept, divide by the day length (reciprocal estimate, remainder,
// one correction), form the day index, divide by the 400-year block length
// the same way, set up, remove whole years inside the block one at a time
// (0 to 399), remove whole months one at a time (0 to 11), check each
// loop's end and load the output register. The year loop of the shared
// subtractor accounts for most of the variation in conversion time.
// One word is worked on at a time; the next is accepted once the result has
// moved to the output register, so the output may hold a word while the next
// conversion runs. If the receiver stalls with a word still held, the
// finished result waits inside until the output register is free.
// Reset (synchronous, active low) returns to idle and empties the output.
// ----------------------------------------------------------------------------
module seconds_to_calendar_date #(
    parameter int unsigned MAX_YEAR = stcd_pkg::DEF_MAX_YEAR
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire  [stcd_pkg::SECS_W-1:0]      i_time_seconds,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic [stcd_pkg::OYEAR_W-1:0]     o_year,
    output logic [stcd_pkg::OMONTH_W-1:0]    o_month,
    output logic [stcd_pkg::ODAY_W-1:0]      o_day,
    output logic                             o_year_overflow
);
    import stcd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    stcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Arithmetic and output register
    stcd_datapath #(
        .MAX_YEAR (MAX_YEAR)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_time_seconds  (i_time_seconds),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_year          (o_year),
        .o_month         (o_month),
        .o_day           (o_day),
        .o_year_overflow (o_year_overflow)
    );

endmodule
`default_nettype wire
